// File: hdl/bsfr_pkg.sv
`default_nettype none

package bsfr_pkg;

    localparam logic [7:0] PREAMBLE_BYTE = 8'h7E;
    localparam logic [7:0] ESCAPE_BYTE   = 8'h7D;
    localparam logic [7:0] ESCAPE_XOR    = 8'h20;

    localparam logic [3:0] MAX_PAYLOAD_RESET = 4'd15;

    // Receiver phase
    typedef enum logic [1:0] {
        PH_HUNT    = 2'd0,
        PH_HEADER  = 2'd1,
        PH_PAYLOAD = 2'd2,
        PH_TRAILER = 2'd3
    } t_phase;

    // Result event codes
    typedef enum logic [2:0] {
        EV_PAYLOAD   = 3'd0,
        EV_GOOD      = 3'd1,
        EV_CSUM_ERR  = 3'd2,
        EV_OVERFLOW  = 3'd3,
        EV_JUNK      = 3'd4,
        EV_UNEXP_PRE = 3'd5
    } t_event;

    // Header byte positions
    localparam logic [1:0] HDR_LEN_FLAGS = 2'd0;
    localparam logic [1:0] HDR_ADDRESS   = 2'd1;

endpackage

`default_nettype wire

// File: hdl/byte_stuffed_frame_receiver.sv
`default_nettype none

// Channel   | Direction | Handshake                  | Payload
// ----------+-----------+----------------------------+------------------------------------
// line in   | input     | i_in_valid / o_in_stall    | i_line_byte
// result    | output    | o_out_valid / i_out_stall  | o_event_res .. o_frame_flags
// config    | input     | i_cfg_wr_en (no wait)      | i_cfg_wr_data (max_payload)
//
// One line byte per cycle: each transfer is decoded combinationally against the
// receiver state and its result, if any, is registered into the output register.
// The only limit is the output register: input stalls only while a result is held
// there and the sink stalls. Reset (synchronous, active low) returns the receiver to
// hunting for a preamble, clears the output valid and sets max_payload to 15.
module byte_stuffed_frame_receiver (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,

    input  wire logic                  i_cfg_wr_en,
    input  wire logic [3:0]            i_cfg_wr_data,

    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire logic [7:0]            i_line_byte,

    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output bsfr_pkg::t_event           o_event_res,
    output logic [7:0]                 o_payload_byte,
    output logic [3:0]                 o_byte_index,
    output logic                       o_last_payload,
    output logic [7:0]                 o_frame_address,
    output logic [7:0]                 o_msg_code,
    output logic [3:0]                 o_frame_length,
    output logic [3:0]                 o_frame_flags
);
    import bsfr_pkg::*;

    // Receiver state
    logic [3:0]  r_max_payload;
    t_phase      r_phase,        n_phase;
    logic        r_esc,          n_esc;
    logic [1:0]  r_hdr_cnt,      n_hdr_cnt;
    logic [7:0]  r_len_flags,    n_len_flags;
    logic [7:0]  r_address,      n_address;
    logic [7:0]  r_code,         n_code;
    logic [3:0]  r_pay_cnt,      n_pay_cnt;
    logic [15:0] r_sum,          n_sum;
    logic        r_trl_cnt,      n_trl_cnt;
    logic [7:0]  r_sum_high,     n_sum_high;

    // Output register
    logic        r_out_valid;
    t_event      r_event,        n_event;
    logic [7:0]  r_pay_byte,     n_pay_byte;
    logic [3:0]  r_byte_idx,     n_byte_idx;
    logic        r_last,         n_last;
    logic [7:0]  r_out_addr,     n_out_addr;
    logic [7:0]  r_out_code,     n_out_code;
    logic [3:0]  r_out_len,      n_out_len;
    logic [3:0]  r_out_flags,    n_out_flags;
    logic        n_res_valid;

    logic        w_out_free;
    logic        w_in_xfer;
    logic        w_preamble;
    logic        w_esc_start;
    logic [7:0]  w_byte;
    logic [3:0]  w_len;
    logic        w_overflow;
    logic        w_last;
    logic        w_sum_ok;

    // Accept a new byte whenever the output slot is empty or being drained
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign o_in_stall = !w_out_free;
    assign w_in_xfer  = i_in_valid && w_out_free;

    // De-escape: a preamble always wins, even right after an escape
    assign w_preamble  = (i_line_byte == PREAMBLE_BYTE);
    assign w_esc_start = !r_esc && (i_line_byte == ESCAPE_BYTE);
    assign w_byte      = r_esc ? (i_line_byte ^ ESCAPE_XOR) : i_line_byte;

    assign w_len      = r_len_flags[7:4];
    assign w_overflow = (w_len > r_max_payload);
    assign w_last     = ({1'b0, r_pay_cnt} + 5'd1) >= {1'b0, w_len};
    assign w_sum_ok   = ({r_sum_high, w_byte} == r_sum);

    // Next state
    always_comb begin
        n_phase     = r_phase;
        n_esc       = r_esc;
        n_hdr_cnt   = r_hdr_cnt;
        n_len_flags = r_len_flags;
        n_address   = r_address;
        n_code      = r_code;
        n_pay_cnt   = r_pay_cnt;
        n_sum       = r_sum;
        n_trl_cnt   = r_trl_cnt;
        n_sum_high  = r_sum_high;

        if (w_preamble) begin
            // Restart the frame from any phase
            n_phase   = PH_HEADER;
            n_esc     = 1'b0;
            n_hdr_cnt = '0;
            n_pay_cnt = '0;
            n_trl_cnt = 1'b0;
            n_sum     = '0;
        end else if (w_esc_start) begin
            n_esc = 1'b1;
        end else begin
            n_esc = 1'b0;
            case (r_phase)
                PH_HUNT: begin
                end
                PH_HEADER: begin
                    n_sum = r_sum + {8'd0, w_byte};
                    if (r_hdr_cnt == HDR_LEN_FLAGS) begin
                        n_len_flags = w_byte;
                        n_hdr_cnt   = 2'd1;
                    end else if (r_hdr_cnt == HDR_ADDRESS) begin
                        n_address = w_byte;
                        n_hdr_cnt = 2'd2;
                    end else begin
                        n_code    = w_byte;
                        n_hdr_cnt = '0;
                        if (w_overflow) begin
                            n_phase = PH_HUNT;
                        end else begin
                            n_pay_cnt = '0;
                            n_trl_cnt = 1'b0;
                            n_phase   = (w_len == 4'd0) ? PH_TRAILER : PH_PAYLOAD;
                        end
                    end
                end
                PH_PAYLOAD: begin
                    n_sum     = r_sum + {8'd0, w_byte};
                    n_pay_cnt = r_pay_cnt + 4'd1;
                    if (w_last) begin
                        n_phase   = PH_TRAILER;
                        n_trl_cnt = 1'b0;
                    end
                end
                PH_TRAILER: begin
                    if (!r_trl_cnt) begin
                        n_sum_high = w_byte;
                        n_trl_cnt  = 1'b1;
                    end else begin
                        n_trl_cnt = 1'b0;
                        n_phase   = PH_HUNT;
                    end
                end
                default: begin
                    n_phase = PH_HUNT;
                end
            endcase
        end
    end

    // Result for this byte
    always_comb begin
        logic with_hdr;
        with_hdr    = 1'b0;
        n_res_valid = 1'b0;
        n_event     = EV_JUNK;
        n_pay_byte  = '0;
        n_byte_idx  = '0;
        n_last      = 1'b0;

        if (w_preamble) begin
            n_res_valid = (r_phase != PH_HUNT);
            n_event     = EV_UNEXP_PRE;
        end else if (!w_esc_start) begin
            case (r_phase)
                PH_HUNT: begin
                    n_res_valid = 1'b1;
                    n_event     = EV_JUNK;
                end
                PH_HEADER: begin
                    if ((r_hdr_cnt != HDR_LEN_FLAGS) && (r_hdr_cnt != HDR_ADDRESS)
                            && w_overflow) begin
                        n_res_valid = 1'b1;
                        n_event     = EV_OVERFLOW;
                        with_hdr    = 1'b1;
                    end
                end
                PH_PAYLOAD: begin
                    n_res_valid = 1'b1;
                    n_event     = EV_PAYLOAD;
                    n_pay_byte  = w_byte;
                    n_byte_idx  = r_pay_cnt;
                    n_last      = w_last;
                    with_hdr    = 1'b1;
                end
                PH_TRAILER: begin
                    if (r_trl_cnt) begin
                        n_res_valid = 1'b1;
                        n_event     = w_sum_ok ? EV_GOOD : EV_CSUM_ERR;
                        with_hdr    = 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end

        // Header fields come from the header as stored after this byte
        n_out_addr  = with_hdr ? n_address        : 8'd0;
        n_out_code  = with_hdr ? n_code           : 8'd0;
        n_out_len   = with_hdr ? n_len_flags[7:4] : 4'd0;
        n_out_flags = with_hdr ? n_len_flags[3:0] : 4'd0;
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_payload <= MAX_PAYLOAD_RESET;
            r_phase       <= PH_HUNT;
            r_esc         <= 1'b0;
            r_hdr_cnt     <= '0;
            r_len_flags   <= '0;
            r_address     <= '0;
            r_code        <= '0;
            r_pay_cnt     <= '0;
            r_sum         <= '0;
            r_trl_cnt     <= 1'b0;
            r_sum_high    <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_max_payload <= i_cfg_wr_data;
            end
            if (w_in_xfer) begin
                r_phase     <= n_phase;
                r_esc       <= n_esc;
                r_hdr_cnt   <= n_hdr_cnt;
                r_len_flags <= n_len_flags;
                r_address   <= n_address;
                r_code      <= n_code;
                r_pay_cnt   <= n_pay_cnt;
                r_sum       <= n_sum;
                r_trl_cnt   <= n_trl_cnt;
                r_sum_high  <= n_sum_high;
                r_out_valid <= n_res_valid;
            end else if (!i_out_stall) begin
                // Drop the result once the sink has taken it
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload: load only when a new result is produced
    always_ff @(posedge i_clk) begin
        if (w_in_xfer && n_res_valid) begin
            r_event     <= n_event;
            r_pay_byte  <= n_pay_byte;
            r_byte_idx  <= n_byte_idx;
            r_last      <= n_last;
            r_out_addr  <= n_out_addr;
            r_out_code  <= n_out_code;
            r_out_len   <= n_out_len;
            r_out_flags <= n_out_flags;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_event_res     = r_event;
    assign o_payload_byte  = r_pay_byte;
    assign o_byte_index    = r_byte_idx;
    assign o_last_payload  = r_last;
    assign o_frame_address = r_out_addr;
    assign o_msg_code      = r_out_code;
    assign o_frame_length  = r_out_len;
    assign o_frame_flags   = r_out_flags;

endmodule

`default_nettype wire
